/* hw/rtl/clkr_pkg.sv */
// ----------------------------------------------------------------------------
// clkr_pkg: shared constants and types for the CSV line key router
// Sizes, byte codes, status codes, register indexes and the structs that
// travel between the line accumulator, the key cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package clkr_pkg;

    localparam int KEY_SLOTS      = 256;
    localparam int MAX_LINE_BYTES = 1048576;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int HELD_W = $clog2(KEY_SLOTS + 1);
    localparam int BCNT_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int STRM_W = (SLOT_W > 8) ? SLOT_W : 8;

    localparam int HASH_W     = 64;
    localparam int LEN_W      = 21;
    localparam int LINE_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam logic [7:0] BYTE_NEWLINE    = 8'd10;
    localparam logic [7:0] BYTE_COMMA      = 8'd44;
    localparam logic [7:0] EXP_COMMAS_RST  = 8'd13;

    // line status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_COMMA   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIELD_CNT  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_CHECK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_COMMAS  = 8'd1;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [SLOT_W-1:0] t_slot;

    // search token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  hit;
        t_slot slot;
    } t_tok;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic  launch;
        t_hash query;
        logic  wr_en;
        t_slot wr_slot;
    } t_chain_ctl;

    // per-line running statistics
    typedef struct packed {
        t_hash             hash;
        logic              comma_seen;
        logic [BCNT_W-1:0] bytes;
        logic [7:0]        commas;
    } t_line;

endpackage

`default_nettype wire

/* hw/rtl/clkr_ifs.sv */
// ----------------------------------------------------------------------------
// clkr_ifs: channel interfaces of the CSV line key router
// Byte input, line record output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface clkr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface clkr_rec_if;
    import clkr_pkg::*;
    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   key_hash;
    logic [7:0]          stream_number;
    logic                is_new_key;
    logic [LEN_W-1:0]    line_length;
    logic [7:0]          comma_count;
    logic [LINE_W-1:0]   line_number;
    logic [STATUS_W-1:0] status;
    modport source (output valid, output key_hash, output stream_number,
                    output is_new_key, output line_length, output comma_count,
                    output line_number, output status, input ready);
    modport sink   (input valid, input key_hash, input stream_number,
                    input is_new_key, input line_length, input comma_count,
                    input line_number, input status, output ready);
endinterface

interface clkr_cfg_if;
    import clkr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/csv_line_key_router.sv */
// ----------------------------------------------------------------------------
// csv_line_key_router: CSV line classifier keyed by the first field
// Hashes each line's first field, looks it up in a key table built from a
// row of cells, and emits one record word per line.
// ----------------------------------------------------------------------------
//   channel   dir  word contents
//   i_byte    in   data_byte: one byte of CSV text
//   o_rec     out  key_hash, stream_number, is_new_key, line_length,
//                  comma_count, line_number, status
//   i_cfg     in   index, data: register write (0 field check, 1 commas)
//
// A non-newline byte is accepted even while a lookup runs.
// A newline that needs the key table sends a token down the cell row, and a
// further newline waits until that line's record moves to the output register.
// Lines flagged no comma, too long or field mismatch skip the table.
// Synchronous active-low reset clears every slot valid flag at once.
// The output register lets intake take one further line while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_key_router (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clkr_byte_if.sink   i_byte,
    clkr_rec_if.source  o_rec,
    clkr_cfg_if.sink    i_cfg
);
    import clkr_pkg::*;

    // configuration
    logic       r_fce;
    logic [7:0] r_exp;

    // line accumulator
    t_line w_line;
    logic  w_is_nl;
    logic  w_acc;
    logic  w_nl;

    // pending line record, waiting for the lookup and for the output
    logic                r_pend_valid;
    logic                r_pend_search;
    logic                r_pend_done;
    logic                r_pend_hit;
    t_slot               r_pend_slot;
    t_hash               r_p_hash;
    logic [LEN_W-1:0]    r_p_len;
    logic [7:0]          r_p_commas;
    logic [LINE_W-1:0]   r_p_line;
    logic [STATUS_W-1:0] r_p_status;

    logic              r_launch;
    logic [LINE_W-1:0] r_lines;
    logic [HELD_W-1:0] r_keys_held;

    // newline decode
    logic                w_too_long;
    logic [BCNT_W-1:0]   w_len;
    logic [STATUS_W-1:0] w_status;

    // completion
    t_tok                w_tail;
    t_chain_ctl          w_ctl;
    logic                w_fin;
    logic                w_insert;
    t_slot               w_stream;
    logic                w_fresh;
    logic [STATUS_W-1:0] w_fin_status;
    logic [STRM_W-1:0]   w_stream_ext;

    // output register
    logic                r_out_valid;
    t_hash               r_o_hash;
    logic [7:0]          r_o_stream;
    logic                r_o_fresh;
    logic [LEN_W-1:0]    r_o_len;
    logic [7:0]          r_o_commas;
    logic [LINE_W-1:0]   r_o_line;
    logic [STATUS_W-1:0] r_o_status;

    // ---------------- intake ----------------
    // Hold a newline while the previous line's record is still pending.
    assign w_is_nl      = (i_byte.data_byte == BYTE_NEWLINE);
    assign i_byte.ready = !r_pend_valid || !w_is_nl;
    assign w_acc        = i_byte.valid && i_byte.ready;
    assign w_nl         = w_acc && w_is_nl;

    clkr_line_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_acc),
        .i_byte   (i_byte.data_byte),
        .o_line   (w_line)
    );

    // Status priority: no comma, too long, field count; table full comes later.
    always_comb begin
        w_too_long = (w_line.bytes >= BCNT_W'(MAX_LINE_BYTES));
        w_len      = w_too_long ? BCNT_W'(MAX_LINE_BYTES) : (w_line.bytes + BCNT_W'(1));
        priority if (!w_line.comma_seen) begin
            w_status = ST_NO_COMMA;
        end else if (w_too_long) begin
            w_status = ST_TOO_LONG;
        end else if (r_fce && (w_line.commas != r_exp)) begin
            w_status = ST_FIELD_CNT;
        end else begin
            w_status = ST_OK;
        end
    end

    // ---------------- key table ----------------
    assign w_ctl.launch  = r_launch;
    assign w_ctl.query   = r_p_hash;
    assign w_ctl.wr_en   = w_insert;
    assign w_ctl.wr_slot = r_keys_held[SLOT_W-1:0];

    clkr_key_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_tok   (w_tail)
    );

    // ---------------- completion ----------------
    // Advance the pending record once its lookup is done and the output is free.
    assign w_fin = r_pend_valid && (!r_pend_search || r_pend_done)
                   && (!r_out_valid || o_rec.ready);

    always_comb begin
        w_insert     = 1'b0;
        w_stream     = '0;
        w_fresh      = 1'b0;
        w_fin_status = r_p_status;
        if (r_pend_search) begin
            if (r_pend_hit) begin
                w_stream = r_pend_slot;
            end else if (r_keys_held < HELD_W'(KEY_SLOTS)) begin
                w_stream = r_keys_held[SLOT_W-1:0];
                w_fresh  = 1'b1;
                w_insert = w_fin;
            end else begin
                w_fin_status = ST_TABLE_FULL;
            end
        end
        w_stream_ext = STRM_W'(w_stream);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fce         <= 1'b0;
            r_exp         <= EXP_COMMAS_RST;
            r_pend_valid  <= 1'b0;
            r_pend_search <= 1'b0;
            r_pend_done   <= 1'b0;
            r_launch      <= 1'b0;
            r_lines       <= '0;
            r_keys_held   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_FIELD_CHECK: r_fce <= i_cfg.data[0];
                    REG_EXP_COMMAS:  r_exp <= i_cfg.data;
                    default: ;
                endcase
            end

            r_launch <= w_nl && (w_status == ST_OK);

            if (w_nl) begin
                r_pend_valid  <= 1'b1;
                r_pend_search <= (w_status == ST_OK);
                r_pend_done   <= 1'b0;
                r_lines       <= r_lines + LINE_W'(1);
            end else begin
                if (w_tail.valid) begin
                    r_pend_done <= 1'b1;
                end
                if (w_fin) begin
                    r_pend_valid <= 1'b0;
                end
            end

            if (w_insert) begin
                r_keys_held <= r_keys_held + HELD_W'(1);
            end

            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_nl) begin
            r_p_hash   <= w_line.hash;
            r_p_len    <= LEN_W'(w_len);
            r_p_commas <= w_line.commas;
            r_p_line   <= r_lines;
            r_p_status <= w_status;
        end
        if (w_tail.valid) begin
            r_pend_hit  <= w_tail.hit;
            r_pend_slot <= w_tail.slot;
        end
        if (w_fin) begin
            r_o_hash   <= r_p_hash;
            r_o_stream <= w_stream_ext[7:0];
            r_o_fresh  <= w_fresh;
            r_o_len    <= r_p_len;
            r_o_commas <= r_p_commas;
            r_o_line   <= r_p_line;
            r_o_status <= w_fin_status;
        end
    end

    // ---------------- ports ----------------
    assign i_cfg.ready         = 1'b1;
    assign o_rec.valid         = r_out_valid;
    assign o_rec.key_hash      = r_o_hash;
    assign o_rec.stream_number = r_o_stream;
    assign o_rec.is_new_key    = r_o_fresh;
    assign o_rec.line_length   = r_o_len;
    assign o_rec.comma_count   = r_o_commas;
    assign o_rec.line_number   = r_o_line;
    assign o_rec.status        = r_o_status;

endmodule

`default_nettype wire

/* hw/rtl/clkr_line_acc.sv */
// ----------------------------------------------------------------------------
// clkr_line_acc: per-line accumulator
// Hashes the first field, counts bytes and commas; clears on newline.
// ----------------------------------------------------------------------------
`default_nettype none

module clkr_line_acc (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_byte,
    output clkr_pkg::t_line     o_line
);
    import clkr_pkg::*;

    t_line r_line;
    t_line n_line;

    always_comb begin
        n_line = r_line;
        if (i_accept) begin
            if (i_byte == BYTE_NEWLINE) begin
                n_line.hash       = HASH_SEED;
                n_line.comma_seen = 1'b0;
                n_line.bytes      = '0;
                n_line.commas     = '0;
            end else begin
                if (i_byte == BYTE_COMMA) begin
                    n_line.comma_seen = 1'b1;
                    if (r_line.commas != 8'hFF) begin
                        n_line.commas = r_line.commas + 8'd1;
                    end
                end else if (!r_line.comma_seen) begin
                    // hash * 33 + byte
                    n_line.hash = (r_line.hash << 5) + r_line.hash + {56'd0, i_byte};
                end
                if (r_line.bytes < BCNT_W'(MAX_LINE_BYTES)) begin
                    n_line.bytes = r_line.bytes + BCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line.hash       <= HASH_SEED;
            r_line.comma_seen <= 1'b0;
            r_line.bytes      <= '0;
            r_line.commas     <= '0;
        end else begin
            r_line <= n_line;
        end
    end

    assign o_line = r_line;

endmodule

`default_nettype wire

/* hw/rtl/clkr_key_cell.sv */
// ----------------------------------------------------------------------------
// clkr_key_cell: one slot of the key table
// Holds one key hash and its valid flag; compares it with the broadcast query and marks the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none

module clkr_key_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire clkr_pkg::t_slot     i_index,
    input  wire clkr_pkg::t_chain_ctl i_ctl,
    input  wire clkr_pkg::t_tok      i_tok,
    output clkr_pkg::t_tok      o_tok
);
    import clkr_pkg::*;

    t_hash r_key;
    logic  r_valid;
    t_tok  r_tok;
    t_tok  n_tok;
    logic  w_match;
    logic  w_write;

    assign w_write = i_ctl.wr_en && (i_ctl.wr_slot == i_index);
    assign w_match = r_valid && (r_key == i_ctl.query);

    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.hit   = i_tok.hit || w_match;
        n_tok.slot  = i_tok.hit ? i_tok.slot : i_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
            r_tok.hit   <= 1'b0;
            r_tok.slot  <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_key <= i_ctl.query;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hw/rtl/clkr_key_chain.sv */
// ----------------------------------------------------------------------------
// clkr_key_chain: row of key cells
// A search token enters the first cell and advances one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clkr_key_chain (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clkr_pkg::t_chain_ctl i_ctl,
    output clkr_pkg::t_tok            o_tok
);
    import clkr_pkg::*;

    t_tok w_tok [KEY_SLOTS+1];

    assign w_tok[0] = '{valid: i_ctl.launch, hit: 1'b0, slot: '0};

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cell
        clkr_key_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (SLOT_W'(g)),
            .i_ctl   (i_ctl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[KEY_SLOTS];

endmodule

`default_nettype wire
